// ===== hdl/slrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Sequenced log ring buffer package
// Field widths, command codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package slrb_pkg;

    localparam int SEQ_W   = 48;
    localparam int WORD_W  = 32;
    localparam int TYPE_W  = 3;
    localparam int LIMIT_W = 7;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;
        logic clear;
        logic start;
        logic step;
        logic finish;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic pend_vld;
        logic out_free;
        logic scan_done;
    } t_sts;

endpackage

// ===== hdl/slrb_if.sv =====
// ----------------------------------------------------------------------------
// Sequenced log ring buffer channels
// Valid/ready channels for command transactions and for result transactions.
// ----------------------------------------------------------------------------
interface slrb_in_if;
    logic                              valid;
    logic                              ready;
    logic [slrb_pkg::CMD_W-1:0]        command;
    logic [slrb_pkg::WORD_W-1:0]       payload;
    logic [slrb_pkg::TYPE_W-1:0]       msg_type;
    logic [slrb_pkg::WORD_W-1:0]       stamp_ms;
    logic [slrb_pkg::SEQ_W-1:0]        cursor;
    logic [slrb_pkg::LIMIT_W-1:0]      limit;

    modport source (
        output valid, command, payload, msg_type, stamp_ms, cursor, limit,
        input  ready
    );
    modport sink (
        input  valid, command, payload, msg_type, stamp_ms, cursor, limit,
        output ready
    );
endinterface

interface slrb_out_if;
    logic                              valid;
    logic                              ready;
    logic [slrb_pkg::SEQ_W-1:0]        entry_seq;
    logic [slrb_pkg::WORD_W-1:0]       entry_payload;
    logic [slrb_pkg::TYPE_W-1:0]       entry_type;
    logic [slrb_pkg::WORD_W-1:0]       entry_stamp;
    logic                              entry_valid;
    logic                              last;
    logic [slrb_pkg::SEQ_W-1:0]        newest_seq;

    modport source (
        output valid, entry_seq, entry_payload, entry_type, entry_stamp,
               entry_valid, last, newest_seq,
        input  ready
    );
    modport sink (
        input  valid, entry_seq, entry_payload, entry_type, entry_stamp,
               entry_valid, last, newest_seq,
        output ready
    );
endinterface

// ===== hdl/slrb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/slrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sequenced log ring buffer controller
// Accepts command transactions and sequences the read scan and its finish.
// ----------------------------------------------------------------------------
module slrb_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [slrb_pkg::CMD_W-1:0] i_command,
    input  slrb_pkg::t_sts             i_sts,
    output logic                       o_in_ready,
    output slrb_pkg::t_ctl             o_ctl
);

    slrb_pkg::t_state r_state;
    slrb_pkg::t_state n_state;
    logic             w_accept;

    assign w_accept = i_in_valid && (r_state == slrb_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slrb_pkg::ST_IDLE: begin
                if (w_accept && (i_command == slrb_pkg::CMD_READ)) begin
                    n_state = slrb_pkg::ST_SCAN;
                end
            end
            slrb_pkg::ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = slrb_pkg::ST_FINISH;
                end
            end
            slrb_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = slrb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_ctl      = '0;
        unique case (r_state)
            slrb_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_ctl.push   = w_accept && (i_command == slrb_pkg::CMD_PUSH);
                o_ctl.clear  = w_accept && (i_command == slrb_pkg::CMD_CLEAR);
                o_ctl.start  = w_accept && (i_command == slrb_pkg::CMD_READ);
            end
            slrb_pkg::ST_SCAN: begin
                // A new hit would push the pending hit out; wait for room.
                o_ctl.step = !i_sts.scan_done &&
                             !(i_sts.hit && i_sts.pend_vld && !i_sts.out_free);
            end
            slrb_pkg::ST_FINISH: begin
                o_ctl.finish = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slrb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/slrb_dp.sv =====
// ----------------------------------------------------------------------------
// Sequenced log ring buffer datapath
// Entry store, ring pointers, sequence counter, scan counters, pending hit
// and the output register.
// ----------------------------------------------------------------------------
module slrb_dp #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  slrb_pkg::t_ctl               i_ctl,
    output slrb_pkg::t_sts               o_sts,
    input  logic [slrb_pkg::WORD_W-1:0]  i_payload,
    input  logic [slrb_pkg::TYPE_W-1:0]  i_msg_type,
    input  logic [slrb_pkg::WORD_W-1:0]  i_stamp_ms,
    input  logic [slrb_pkg::SEQ_W-1:0]   i_cursor,
    input  logic [slrb_pkg::LIMIT_W-1:0] i_limit,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [slrb_pkg::SEQ_W-1:0]   o_entry_seq,
    output logic [slrb_pkg::WORD_W-1:0]  o_entry_payload,
    output logic [slrb_pkg::TYPE_W-1:0]  o_entry_type,
    output logic [slrb_pkg::WORD_W-1:0]  o_entry_stamp,
    output logic                         o_entry_valid,
    output logic                         o_last,
    output logic [slrb_pkg::SEQ_W-1:0]   o_newest_seq
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [slrb_pkg::SEQ_W-1:0]  seq;
        logic [slrb_pkg::WORD_W-1:0] payload;
        logic [slrb_pkg::TYPE_W-1:0] msg_type;
        logic [slrb_pkg::WORD_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        t_entry                     entry;
        logic                       valid;
        logic                       last;
        logic [slrb_pkg::SEQ_W-1:0] newest;
    } t_result;

    localparam int MW = $bits(t_entry);

    // Control registers.
    logic [AW-1:0]              r_wr_idx,   n_wr_idx;
    logic [CW-1:0]              r_fill,     n_fill;
    logic [slrb_pkg::SEQ_W-1:0] r_seq_cnt,  n_seq_cnt;
    logic [CW-1:0]              r_got,      n_got;
    logic [CW-1:0]              r_issued,   n_issued;
    logic                       r_dvalid,   n_dvalid;
    logic                       r_pend_vld, n_pend_vld;
    logic                       r_out_vld,  n_out_vld;

    // Payload registers.
    logic [slrb_pkg::SEQ_W-1:0] r_cur,      n_cur;
    logic [CW-1:0]              r_lim,      n_lim;
    logic [AW-1:0]              r_rd_addr,  n_rd_addr;
    t_entry                     r_pend,     n_pend;
    t_result                    r_out,      n_out;

    logic [MW-1:0]              w_wr_data;
    logic [MW-1:0]              w_rd_data;
    t_entry                     w_rd_entry;
    logic                       w_issue;
    logic                       w_hit;
    logic                       w_out_free;
    logic [slrb_pkg::SEQ_W-1:0] w_latest;
    logic [slrb_pkg::SEQ_W-1:0] w_newest;
    logic [CW-1:0]              w_lim_sat;
    logic [slrb_pkg::SEQ_W-1:0] w_lim_ext;
    logic [slrb_pkg::SEQ_W-1:0] w_cur_start;
    logic [AW-1:0]              w_oldest;

    assign w_wr_data  = {r_seq_cnt, i_payload, i_msg_type, i_stamp_ms};
    assign w_rd_entry = t_entry'(w_rd_data);
    assign w_issue    = i_ctl.step && (r_issued != r_fill);
    assign w_hit      = r_dvalid && (w_rd_entry.seq > r_cur);
    assign w_out_free = !r_out_vld || i_out_ready;

    // With at least one entry stored, the newest one carries the counter minus one.
    assign w_latest = r_seq_cnt - slrb_pkg::SEQ_W'(1);
    assign w_newest = (r_seq_cnt <= slrb_pkg::SEQ_W'(1)) ? '0 : w_latest;

    assign w_lim_sat = (i_limit > slrb_pkg::LIMIT_W'(DEPTH)) ? CW'(DEPTH) : CW'(i_limit);
    assign w_lim_ext = slrb_pkg::SEQ_W'(w_lim_sat);

    always_comb begin
        if (i_cursor != '0) begin
            w_cur_start = i_cursor;
        end else if (w_latest > w_lim_ext) begin
            w_cur_start = w_latest - w_lim_ext;
        end else begin
            w_cur_start = '0;
        end
    end

    assign w_oldest = (r_fill < CW'(DEPTH)) ? '0 : r_wr_idx;

    assign o_sts.hit       = w_hit;
    assign o_sts.pend_vld  = r_pend_vld;
    assign o_sts.out_free  = w_out_free;
    assign o_sts.scan_done = (r_got == r_lim) || (!r_dvalid && (r_issued == r_fill));

    slrb_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.push),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_wr_idx   = r_wr_idx;
        n_fill     = r_fill;
        n_seq_cnt  = r_seq_cnt;
        n_got      = r_got;
        n_issued   = r_issued;
        n_dvalid   = r_dvalid;
        n_pend_vld = r_pend_vld;
        n_cur      = r_cur;
        n_lim      = r_lim;
        n_rd_addr  = r_rd_addr;
        n_pend     = r_pend;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_out_ready;

        if (i_ctl.push) begin
            n_seq_cnt = r_seq_cnt + slrb_pkg::SEQ_W'(1);
            n_wr_idx  = (r_wr_idx == AW'(DEPTH - 1)) ? '0 : r_wr_idx + AW'(1);
            if (r_fill < CW'(DEPTH)) begin
                n_fill = r_fill + CW'(1);
            end
        end

        if (i_ctl.clear) begin
            n_wr_idx  = '0;
            n_fill    = '0;
            n_seq_cnt = slrb_pkg::SEQ_W'(1);
        end

        if (i_ctl.start) begin
            n_cur      = w_cur_start;
            n_lim      = w_lim_sat;
            n_got      = '0;
            n_issued   = '0;
            n_rd_addr  = w_oldest;
            n_dvalid   = 1'b0;
            n_pend_vld = 1'b0;
        end

        if (i_ctl.step) begin
            n_dvalid = w_issue;
            if (w_issue) begin
                n_issued  = r_issued + CW'(1);
                n_rd_addr = (r_rd_addr == AW'(DEPTH - 1)) ? '0 : r_rd_addr + AW'(1);
            end
            if (w_hit) begin
                n_got      = r_got + CW'(1);
                n_pend     = w_rd_entry;
                n_pend_vld = 1'b1;
                if (r_pend_vld) begin
                    n_out_vld    = 1'b1;
                    n_out.entry  = r_pend;
                    n_out.valid  = 1'b1;
                    n_out.last   = 1'b0;
                    n_out.newest = w_newest;
                end
            end
        end

        if (i_ctl.finish) begin
            n_out_vld    = 1'b1;
            n_out.last   = 1'b1;
            n_out.newest = w_newest;
            if (r_pend_vld) begin
                n_out.entry = r_pend;
                n_out.valid = 1'b1;
            end else begin
                n_out.entry = '0;
                n_out.valid = 1'b0;
            end
            n_pend_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx   <= '0;
            r_fill     <= '0;
            r_seq_cnt  <= slrb_pkg::SEQ_W'(1);
            r_got      <= '0;
            r_issued   <= '0;
            r_dvalid   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_wr_idx   <= n_wr_idx;
            r_fill     <= n_fill;
            r_seq_cnt  <= n_seq_cnt;
            r_got      <= n_got;
            r_issued   <= n_issued;
            r_dvalid   <= n_dvalid;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_lim     <= n_lim;
        r_rd_addr <= n_rd_addr;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    assign o_out_valid     = r_out_vld;
    assign o_entry_seq     = r_out.entry.seq;
    assign o_entry_payload = r_out.entry.payload;
    assign o_entry_type    = r_out.entry.msg_type;
    assign o_entry_stamp   = r_out.entry.stamp;
    assign o_entry_valid   = r_out.valid;
    assign o_last          = r_out.last;
    assign o_newest_seq    = r_out.newest;

endmodule

// ===== hdl/sequenced_log_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// Sequenced log ring buffer
// Circular store of DEPTH log entries, each tagged with a sequence number,
// with a read that returns up to a limit of the entries above a cursor, oldest first.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Carries
//   i_in      sink        command, payload, msg_type, stamp_ms, cursor, limit
//   o_out     source      entry_seq, entry_payload, entry_type, entry_stamp,
//                         entry_valid, last, newest_seq
//
// A push, a clear or an unused command completes when it is accepted and
// returns nothing. A read is accepted, then scans the stored entries oldest
// first through the single read port of the entry store, which has
// registered read data, until the limit is met or the store is exhausted;
// a finish step then closes the read with the last result.
// Reset is synchronous and active low; it empties the store and restarts the
// sequence at one. A stalled o_out holds the scan only when a further hit
// needs the output register; i_in is taken again once the read has finished.
//
module sequenced_log_ring_buffer #(
    parameter int DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slrb_in_if.sink    i_in,
    slrb_out_if.source o_out
);

    // Controller and datapath talk only through these two bundles.
    slrb_pkg::t_ctl w_ctl;
    slrb_pkg::t_sts w_sts;

    // The controller owns the input handshake. A transaction is taken only
    // while no read is in progress; pushes and clears complete on the spot.
    slrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_command  (i_in.command),
        .i_sts      (w_sts),
        .o_in_ready (i_in.ready),
        .o_ctl      (w_ctl)
    );

    // The datapath holds the entry store, the ring pointers, the scan and
    // the output register. The last hit found is kept pending until the
    // next hit or the end of the scan tells whether it closes the read.
    slrb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_payload       (i_in.payload),
        .i_msg_type      (i_in.msg_type),
        .i_stamp_ms      (i_in.stamp_ms),
        .i_cursor        (i_in.cursor),
        .i_limit         (i_in.limit),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_entry_seq     (o_out.entry_seq),
        .o_entry_payload (o_out.entry_payload),
        .o_entry_type    (o_out.entry_type),
        .o_entry_stamp   (o_out.entry_stamp),
        .o_entry_valid   (o_out.entry_valid),
        .o_last          (o_out.last),
        .o_newest_seq    (o_out.newest_seq)
    );

endmodule

// ===== dv/tb_sequenced_log_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// Sequenced log ring buffer testbench
// Drives push, read, clear and unused command transactions into the log
// store, keeps its own copy of the store to predict every read result, and
// checks each result transaction field by field in arrival order. The
// directed corners come first. Random traffic follows under several sender
// and receiver idling mixes, then a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sequenced_log_ring_buffer;

    localparam int LOG_DEPTH = 64;
    localparam int LOG_AW    = $clog2(LOG_DEPTH);
    localparam logic [slrb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [slrb_pkg::SEQ_W-1:0] SEQ_ALL_ONES = {slrb_pkg::SEQ_W{1'b1}};

    // One command transaction as the sender sees it.
    typedef struct packed {
        logic [slrb_pkg::CMD_W-1:0]   command;
        logic [slrb_pkg::WORD_W-1:0]  payload;
        logic [slrb_pkg::TYPE_W-1:0]  msg_type;
        logic [slrb_pkg::WORD_W-1:0]  stamp_ms;
        logic [slrb_pkg::SEQ_W-1:0]   cursor;
        logic [slrb_pkg::LIMIT_W-1:0] limit;
    } t_log_cmd;

    // One result transaction: a returned entry or the empty marker.
    typedef struct packed {
        logic [slrb_pkg::SEQ_W-1:0]  seq;
        logic [slrb_pkg::WORD_W-1:0] payload;
        logic [slrb_pkg::TYPE_W-1:0] kind;
        logic [slrb_pkg::WORD_W-1:0] stamp;
        logic                        present;
        logic                        is_last;
        logic [slrb_pkg::SEQ_W-1:0]  newest;
    } t_log_result;

    logic i_clk;
    logic i_rst_n;

    slrb_in_if  log_in ();
    slrb_out_if log_out ();

    sequenced_log_ring_buffer #(
        .DEPTH(LOG_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (log_in),
        .o_out   (log_out)
    );

    // Shadow copy of the log store. Slots are only read after being written,
    // because a read never looks past the current fill count. The depth is a
    // power of two, so slot pointers wrap on their own.
    logic [slrb_pkg::SEQ_W-1:0]  shadow_seq     [LOG_DEPTH];
    logic [slrb_pkg::WORD_W-1:0] shadow_payload [LOG_DEPTH];
    logic [slrb_pkg::TYPE_W-1:0] shadow_type    [LOG_DEPTH];
    logic [slrb_pkg::WORD_W-1:0] shadow_stamp   [LOG_DEPTH];
    logic [LOG_AW-1:0]           shadow_wr_ptr;
    int unsigned                 shadow_fill;
    logic [slrb_pkg::SEQ_W-1:0]  shadow_seq_cnt;

    // Read results predicted but not yet seen on the output channel.
    t_log_result entries_due[$];

    int fail_count;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_ask;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Absolute limit on the run, far beyond the slowest legal run.
    initial begin
        #18_000_000;
        $display("tb_sequenced_log_ring_buffer: errors");
        $finish;
    end

    // Receiver side. Ready is redrawn at each falling edge. A hold-off asked
    // for by a test is counted down here at each falling edge.
    initial begin
        int hold_left;
        hold_left = 0;
        log_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_ask != 0) begin
                hold_left = hold_ask;
                hold_ask  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                log_out.ready <= 1'b0;
            end else begin
                log_out.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Result checker: every accepted result is matched against the oldest
    // prediction. The first ten failures are printed, the rest only counted.
    always @(posedge i_clk) begin : check_results
        t_log_result got;
        t_log_result want;
        logic        bad;
        if (i_rst_n && log_out.valid && log_out.ready) begin
            got.seq     = log_out.entry_seq;
            got.payload = log_out.entry_payload;
            got.kind    = log_out.entry_type;
            got.stamp   = log_out.entry_stamp;
            got.present = log_out.entry_valid;
            got.is_last = log_out.last;
            got.newest  = log_out.newest_seq;
            if (entries_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR @%0t: result with none expected: seq=%0d valid=%b last=%b",
                             $time, got.seq, got.present, got.is_last);
            end else begin
                want = entries_due.pop_front();
                bad = (got.seq !== want.seq) || (got.payload !== want.payload)
                   || (got.kind !== want.kind) || (got.stamp !== want.stamp)
                   || (got.present !== want.present) || (got.is_last !== want.is_last)
                   || (got.newest !== want.newest);
                if (bad) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("ERROR @%0t: read result mismatch", $time);
                        $display("  expected seq=%0d pl=%h ty=%0d st=%h v=%b l=%b nw=%0d",
                                 want.seq, want.payload, want.kind, want.stamp,
                                 want.present, want.is_last, want.newest);
                        $display("  actual   seq=%0d pl=%h ty=%0d st=%h v=%b l=%b nw=%0d",
                                 got.seq, got.payload, got.kind, got.stamp,
                                 got.present, got.is_last, got.newest);
                    end
                end
            end
        end
    end

    // Apply one accepted command to the shadow store and queue the results
    // that a read is expected to return.
    task automatic log_predict(input t_log_cmd c);
        t_log_result                r;
        logic [slrb_pkg::SEQ_W-1:0] floor_seq;
        logic [slrb_pkg::SEQ_W-1:0] top_seq;
        int unsigned                cap;
        logic [LOG_AW-1:0]          first_slot;
        logic [LOG_AW-1:0]          slot;
        logic [LOG_AW-1:0]          hits[$];
        r = '0;
        r.newest = (shadow_seq_cnt <= 1) ? '0 : shadow_seq_cnt - 1'b1;
        if (c.command == slrb_pkg::CMD_PUSH) begin
            shadow_seq[shadow_wr_ptr]     = shadow_seq_cnt;
            shadow_payload[shadow_wr_ptr] = c.payload;
            shadow_type[shadow_wr_ptr]    = c.msg_type;
            shadow_stamp[shadow_wr_ptr]   = c.stamp_ms;
            shadow_seq_cnt = shadow_seq_cnt + 1'b1;
            shadow_wr_ptr  = shadow_wr_ptr + 1'b1;
            if (shadow_fill < LOG_DEPTH)
                shadow_fill++;
        end else if (c.command == slrb_pkg::CMD_CLEAR) begin
            shadow_wr_ptr  = '0;
            shadow_fill    = 0;
            shadow_seq_cnt = slrb_pkg::SEQ_W'(1);
        end else if (c.command == slrb_pkg::CMD_READ) begin
            // The limit saturates at the depth before anything else.
            cap = (c.limit > LOG_DEPTH) ? LOG_DEPTH : c.limit;
            if (shadow_fill != 0 && cap != 0) begin
                first_slot = (shadow_fill < LOG_DEPTH) ? '0 : shadow_wr_ptr;
                floor_seq  = c.cursor;
                // A zero cursor means "the newest cap entries".
                if (floor_seq == 0) begin
                    top_seq   = shadow_seq[shadow_wr_ptr - 1'b1];
                    floor_seq = (top_seq > cap) ? top_seq - cap : '0;
                end
                for (int i = 0; i < shadow_fill && hits.size() < cap; i++) begin
                    slot = first_slot + LOG_AW'(i);
                    if (shadow_seq[slot] > floor_seq)
                        hits = {hits, slot};
                end
            end
            if (hits.size() == 0) begin
                // Nothing matched: a single empty marker closes the read.
                r.is_last = 1'b1;
                entries_due = {entries_due, r};
            end else begin
                foreach (hits[i]) begin
                    r.seq     = shadow_seq[hits[i]];
                    r.payload = shadow_payload[hits[i]];
                    r.kind    = shadow_type[hits[i]];
                    r.stamp   = shadow_stamp[hits[i]];
                    r.present = 1'b1;
                    r.is_last = (i == hits.size() - 1);
                    entries_due = {entries_due, r};
                end
            end
        end
    endtask

    function automatic t_log_cmd mk_cmd(input logic [slrb_pkg::CMD_W-1:0]   command,
                                        input logic [slrb_pkg::WORD_W-1:0]  payload,
                                        input logic [slrb_pkg::TYPE_W-1:0]  msg_type,
                                        input logic [slrb_pkg::WORD_W-1:0]  stamp_ms,
                                        input logic [slrb_pkg::SEQ_W-1:0]   cursor,
                                        input logic [slrb_pkg::LIMIT_W-1:0] limit);
        t_log_cmd c;
        c.command  = command;
        c.payload  = payload;
        c.msg_type = msg_type;
        c.stamp_ms = stamp_ms;
        c.cursor   = cursor;
        c.limit    = limit;
        return c;
    endfunction

    // Random command, shaped so the store fills and wraps: pushes dominate,
    // clears are rare, and read cursors mostly land near the live sequence.
    function automatic t_log_cmd rand_log_cmd();
        t_log_cmd                   c;
        int unsigned                pick;
        int unsigned                back;
        logic [slrb_pkg::SEQ_W-1:0] top;
        c.payload  = $urandom;
        c.msg_type = slrb_pkg::TYPE_W'($urandom);
        c.stamp_ms = $urandom;
        c.cursor   = slrb_pkg::SEQ_W'({$urandom, $urandom});
        c.limit    = slrb_pkg::LIMIT_W'($urandom_range(63, 1));
        pick = $urandom_range(99);
        if (pick < 2)
            c.command = slrb_pkg::CMD_CLEAR;
        else if (pick < 5)
            c.command = CMD_UNUSED;
        else if (pick < 58)
            c.command = slrb_pkg::CMD_PUSH;
        else
            c.command = slrb_pkg::CMD_READ;
        if (c.command == slrb_pkg::CMD_PUSH && $urandom_range(9) == 0)
            c.payload = $urandom_range(1) ? '1 : '0;
        if (c.command == slrb_pkg::CMD_READ) begin
            top  = (shadow_seq_cnt > 1) ? shadow_seq_cnt - 1'b1 : '0;
            pick = $urandom_range(99);
            if (pick < 30) begin
                c.cursor = '0;
            end else if (pick < 70) begin
                back     = $urandom_range(70);
                c.cursor = (top > back) ? top - back : '0;
            end else if (pick < 85) begin
                c.cursor = top + $urandom_range(3);
            end
            pick = $urandom_range(99);
            if (pick < 8)
                c.limit = '0;
            else if (pick < 20)
                c.limit = slrb_pkg::LIMIT_W'($urandom_range(127, 65));
            else if (pick < 40)
                c.limit = slrb_pkg::LIMIT_W'(LOG_DEPTH);
        end
        return c;
    endfunction

    // Offer one command, starting at a falling edge, and return at the falling
    // edge after it was accepted. Valid stays high on return, so a following
    // command goes out back to back; anyone who stops sending lowers it.
    task automatic send_log_cmd(input t_log_cmd c);
        if ($urandom_range(99) < src_idle_pct) begin
            log_in.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        log_in.valid    <= 1'b1;
        log_in.command  <= c.command;
        log_in.payload  <= c.payload;
        log_in.msg_type <= c.msg_type;
        log_in.stamp_ms <= c.stamp_ms;
        log_in.cursor   <= c.cursor;
        log_in.limit    <= c.limit;
        do @(posedge i_clk); while (!log_in.ready);
        log_predict(c);
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        log_in.valid <= 1'b0;
        while (entries_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Empty store, field extremes, limit zero and above depth, cursor zero,
    // cursor above everything, the unused command, and a clear that restarts
    // the sequence at one.
    task automatic test_directed_corners();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, '0, 7'd5));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_PUSH,  '0, '0, '0, '0, '0));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_PUSH,  '1, 3'd7, '1, '1, '1));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_PUSH,  $urandom, 3'd3, $urandom, '0, '0));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, '0, 7'd0));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, '0, 7'd127));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, 48'd1, 7'd64));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, 48'd3, 7'd64));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, SEQ_ALL_ONES, 7'd64));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, '0, 7'd1));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, '0, 7'd2));
        send_log_cmd(mk_cmd(CMD_UNUSED, $urandom, 3'd5, $urandom,
                            slrb_pkg::SEQ_W'({$urandom, $urandom}), 7'd9));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, 48'd2, 7'd1));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_CLEAR, '0, '0, '0, '0, '0));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, '0, 7'd64));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_PUSH,  $urandom, 3'd6, $urandom, '0, '0));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, '0, 7'd65));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ,  '0, '0, '0, 48'd1, 7'd64));
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct,
                                       input int stall_pct);
        t_log_cmd c;
        int       counted;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        counted = 0;
        while (counted < items) begin
            c = rand_log_cmd();
            send_log_cmd(c);
            if (c.command != CMD_UNUSED)
                counted++;
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering mostly full-depth reads and pushes, so the output register fills and
    // the block stops taking commands until the hold-off ends.
    task automatic test_full_store_stall();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (10) send_log_cmd(mk_cmd(slrb_pkg::CMD_PUSH, $urandom,
                                        slrb_pkg::TYPE_W'($urandom), $urandom, '0, '0));
        log_in.valid <= 1'b0;
        @(posedge i_clk);
        hold_ask = 300;
        @(negedge i_clk);
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ, '0, '0, '0, '0, 7'd64));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_PUSH, $urandom,
                            slrb_pkg::TYPE_W'($urandom), $urandom, '0, '0));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_PUSH, $urandom,
                            slrb_pkg::TYPE_W'($urandom), $urandom, '0, '0));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ, '0, '0, '0, '0, 7'd127));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_PUSH, $urandom,
                            slrb_pkg::TYPE_W'($urandom), $urandom, '0, '0));
        send_log_cmd(mk_cmd(slrb_pkg::CMD_READ, '0, '0, '0, shadow_seq_cnt - 7'd40,
                            7'd40));
    endtask

    // The sender stops until every predicted result has come back, then
    // resumes with the store left exactly as the last read saw it.
    task automatic test_pause_for_drain();
        src_idle_pct  = 0;
        snk_stall_pct = 34;
        repeat (4) send_log_cmd(rand_log_cmd());
        wait_for_drain();
        repeat (4) send_log_cmd(rand_log_cmd());
    endtask

    initial begin
        log_in.valid    = 1'b0;
        log_in.command  = slrb_pkg::CMD_PUSH;
        log_in.payload  = '0;
        log_in.msg_type = '0;
        log_in.stamp_ms = '0;
        log_in.cursor   = '0;
        log_in.limit    = '0;
        i_rst_n         = 1'b0;
        fail_count      = 0;
        hold_ask        = 0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        shadow_wr_ptr   = '0;
        shadow_fill     = 0;
        shadow_seq_cnt  = slrb_pkg::SEQ_W'(1);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_corners();
        test_random_traffic(65, 0, 0);
        test_random_traffic(65, 46, 0);
        test_random_traffic(65, 0, 46);
        test_random_traffic(65, 34, 34);
        test_full_store_stall();
        test_pause_for_drain();

        // Let the last read finish its scan before judging the run.
        wait_for_drain();
        repeat (LOG_DEPTH + 8) @(negedge i_clk);

        if (entries_due.size() != 0) begin
            $display("ERROR: %0d predicted read results never arrived", entries_due.size());
            fail_count += entries_due.size();
        end
        if (fail_count == 0) begin
            $display("tb_sequenced_log_ring_buffer: clean");
        end else begin
            $display("tb_sequenced_log_ring_buffer: errors");
        end
        $finish;
    end

endmodule

// ===== sequenced_log_ring_buffer.f =====
hdl/slrb_pkg.sv
hdl/slrb_if.sv
hdl/slrb_ram.sv
hdl/slrb_ctrl.sv
hdl/slrb_dp.sv
hdl/sequenced_log_ring_buffer.sv
dv/tb_sequenced_log_ring_buffer.sv
